// ===== rtl/dcta_pkg.sv =====
// Shared types and constants for the down-counter time accumulator.
`timescale 1ns / 1ps
package dcta_pkg;

    localparam int unsigned TICK_W   = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned D100_W   = 26;
    localparam int unsigned D1000_W  = 23;
    localparam int unsigned MIN_W    = 17;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned DECI_W   = 4;
    localparam int unsigned OUT_W    = 96;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned STEP_W   = 6;

    localparam logic [WORD_W-1:0] RELOAD_RST  = 32'd65535;
    localparam logic [WORD_W-1:0] DIVISOR_RST = 32'd1000000;

    // Reciprocal constants, exact for every 32-bit dividend
    localparam logic [WORD_W-1:0] RECIP_100 = 32'h51EB_851F; // >> 37
    localparam logic [WORD_W-1:0] RECIP_10  = 32'hCCCC_CCCD; // >> 35
    localparam logic [WORD_W-1:0] RECIP_60  = 32'h8888_8889; // >> 37

    // Register index decoded from paddr[2]
    localparam logic REG_RELOAD  = 1'b0;
    localparam logic REG_DIVISOR = 1'b1;

    typedef struct packed {
        logic load_in;
        logic elap;
        logic accum;
        logic scale;
        logic div_step;
        logic split_a;
        logic split_b;
        logic split_c;
        logic split_d;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic              en;
        logic              sel;
        logic [WORD_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/dcta_ctrl.sv =====
// Sequencing state machine for the down-counter time accumulator.
`timescale 1ns / 1ps
module dcta_ctrl
    import dcta_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAP,
        ST_ACCUM,
        ST_SCALE,
        ST_DIV,
        ST_SPLA,
        ST_SPLB,
        ST_SPLC,
        ST_SPLD,
        ST_LOAD
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              w_load_ok;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    // Output register is free once its transaction completes
    assign w_load_ok  = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = i_s_tvalid && (r_state == ST_IDLE);
        o_cmd.elap     = (r_state == ST_ELAP);
        o_cmd.accum    = (r_state == ST_ACCUM);
        o_cmd.scale    = (r_state == ST_SCALE);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.split_a  = (r_state == ST_SPLA);
        o_cmd.split_b  = (r_state == ST_SPLB);
        o_cmd.split_c  = (r_state == ST_SPLC);
        o_cmd.split_d  = (r_state == ST_SPLD);
        o_cmd.load_out = (r_state == ST_LOAD) && w_load_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_ELAP;
                    end
                end
                ST_ELAP:  r_state <= ST_ACCUM;
                ST_ACCUM: r_state <= ST_SCALE;
                ST_SCALE: begin
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_SPLA;
                    end
                end
                ST_SPLA: r_state <= ST_SPLB;
                ST_SPLB: r_state <= ST_SPLC;
                ST_SPLC: r_state <= ST_SPLD;
                ST_SPLD: r_state <= ST_LOAD;
                ST_LOAD: begin
                    // Hold until the previous result has left
                    if (w_load_ok) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/dcta_dp.sv =====
// Datapath: tick accumulation, millisecond divider and time split.
`timescale 1ns / 1ps
module dcta_dp
    import dcta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_cfg_wr           i_cfg,
    input  logic [WORD_W-1:0] i_sample,
    output logic [WORD_W-1:0] o_reload,
    output logic [WORD_W-1:0] o_divisor,
    output logic [OUT_W-1:0]  o_result
);

    logic [WORD_W-1:0]  r_reload;
    logic [WORD_W-1:0]  r_divisor;
    logic [TICK_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_prev;
    logic [WORD_W-1:0]  r_sample;
    logic [WORD_W-1:0]  r_elapsed;
    logic [TICK_W-1:0]  r_dividend;
    logic [WORD_W-1:0]  r_rem;
    logic [D100_W-1:0]  r_d100;
    logic [D1000_W-1:0] r_d1000;
    logic [MIN_W-1:0]   r_min;
    logic [SEC_W-1:0]   r_sec;
    logic [DECI_W-1:0]  r_deci;
    logic [OUT_W-1:0]   r_result;

    logic [WORD_W-1:0]   n_elapsed;
    logic [TICK_W-1:0]   n_scaled;
    logic [WORD_W:0]     w_shifted;
    logic [WORD_W:0]     w_diff;
    logic                w_ge;
    logic [2*WORD_W-1:0] w_prod_a;
    logic [2*WORD_W-1:0] w_prod_b;
    logic [2*WORD_W-1:0] w_prod_c;
    logic [D100_W-1:0]   w_deci_full;
    logic [D1000_W-1:0]  w_sec_full;

    assign o_reload  = r_reload;
    assign o_divisor = r_divisor;
    assign o_result  = r_result;

    always_comb begin
        if (r_sample > r_prev) begin
            n_elapsed = r_prev + (r_reload - r_sample);
        end else begin
            n_elapsed = r_prev - r_sample;
        end
    end

    // acc * 1000 = acc*1024 - acc*16 - acc*8, modulo 2^64
    assign n_scaled = (r_acc << 10) - (r_acc << 4) - (r_acc << 3);

    // One restoring division step per cycle
    assign w_shifted = {r_rem, r_dividend[TICK_W-1]};
    assign w_ge      = (w_shifted >= {1'b0, r_divisor});
    assign w_diff    = w_shifted - {1'b0, r_divisor};

    assign w_prod_a    = r_dividend[WORD_W-1:0] * RECIP_100;
    assign w_prod_b    = WORD_W'(r_d100) * RECIP_10;
    assign w_prod_c    = WORD_W'(r_d1000) * RECIP_60;
    assign w_deci_full = r_d100 - D100_W'({r_d1000, 3'b000} + {r_d1000, 1'b0});
    assign w_sec_full  = r_d1000 - D1000_W'({r_min, 6'b000000} - {r_min, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= RELOAD_RST;
            r_divisor <= DIVISOR_RST;
            r_acc     <= '0;
            r_prev    <= RELOAD_RST;
        end else begin
            if (i_cfg.en) begin
                case (i_cfg.sel)
                    REG_RELOAD: begin
                        r_reload <= i_cfg.data;
                        r_acc    <= '0;
                        r_prev   <= i_cfg.data;
                    end
                    REG_DIVISOR: r_divisor <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.elap) begin
                r_prev <= r_sample;
            end
            if (i_cmd.accum) begin
                r_acc <= r_acc + TICK_W'(r_elapsed);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
        end
        if (i_cmd.elap) begin
            r_elapsed <= n_elapsed;
        end
        if (i_cmd.scale) begin
            r_dividend <= n_scaled;
            r_rem      <= '0;
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[TICK_W-2:0], w_ge};
            r_rem      <= w_ge ? w_diff[WORD_W-1:0] : w_shifted[WORD_W-1:0];
        end
        if (i_cmd.split_a) begin
            r_d100 <= w_prod_a[37 +: D100_W];
        end
        if (i_cmd.split_b) begin
            r_d1000 <= w_prod_b[35 +: D1000_W];
        end
        if (i_cmd.split_c) begin
            r_min  <= w_prod_c[37 +: MIN_W];
            r_deci <= w_deci_full[DECI_W-1:0];
        end
        if (i_cmd.split_d) begin
            r_sec <= w_sec_full[SEC_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_result <= {5'b00000, r_deci, r_sec, r_min,
                         r_dividend[WORD_W-1:0], r_acc[WORD_W-1:0]};
        end
    end

endmodule

// ===== rtl/down_counter_time_accumulator_top.sv =====
// Top level of the down-counter time accumulator.
`timescale 1ns / 1ps
// Usage:
//   Each slave-side transaction carries one sample of a free-running
//   down-counter. The block folds the elapsed ticks into a 64-bit total and
//   returns one master-side transaction with the low tick count, the
//   millisecond time (1000 * ticks / divisor) and its minute, second and
//   decisecond split.
//   No sample is taken until the last one is through; the 64-step restoring
//   divider forms the millisecond value one quotient bit per cycle.
//   The result sits in an output register; the next sample is taken while
//   it waits. A stalled receiver holds a finished item in the sequencer
//   until the register frees up, and o_s_tready stays low meanwhile.
//   Reset restores reload 65535, divisor 1000000, zero ticks and a previous
//   sample of 65535. The user makes APB writes to reload (0x0) or divisor
//   (0x4) only while the block is idle; the block does not enforce this.
//   Writing reload also clears the tick total.
module down_counter_time_accumulator_top
    import dcta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] counter_reading
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] tick_total_low, [63:32] millis, [80:64] minutes,
    // [86:81] seconds, [90:87] deciseconds, [95:91] zero
    output logic [95:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd           w_cmd;
    t_cfg_wr           w_cfg;
    logic [WORD_W-1:0] w_reload;
    logic [WORD_W-1:0] w_divisor;

    assign pready     = 1'b1;
    assign w_cfg.en   = psel && penable && pwrite;
    assign w_cfg.sel  = paddr[2];
    assign w_cfg.data = pwdata;

    always_comb begin
        case (paddr[2])
            REG_RELOAD:  prdata = w_reload;
            REG_DIVISOR: prdata = w_divisor;
            default:     prdata = '0;
        endcase
    end

    dcta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    dcta_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_cfg     (w_cfg),
        .i_sample  (i_s_tdata),
        .o_reload  (w_reload),
        .o_divisor (w_divisor),
        .o_result  (o_m_tdata)
    );

endmodule

// ===== tb/sv/elapsed_time_checker.sv =====
// Checker that predicts and compares the time stamps of the down-counter time accumulator.
`timescale 1ns / 1ps
module elapsed_time_checker
    import dcta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] counter_reading
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] tick_total_low, [63:32] millis, [80:64] minutes,
    // [86:81] seconds, [90:87] deciseconds, [95:91] zero
    input  logic [95:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count
);

    // Packed lowest field last, so it lines up with o_m_tdata[90:0]
    typedef struct packed {
        logic [DECI_W-1:0] deciseconds;
        logic [SEC_W-1:0]  seconds;
        logic [MIN_W-1:0]  minutes;
        logic [WORD_W-1:0] millis;
        logic [WORD_W-1:0] tick_total_low;
    } t_time_stamp;

    logic [WORD_W-1:0] reload_value;
    logic [WORD_W-1:0] tick_divisor;
    logic [WORD_W-1:0] last_reading;
    logic [TICK_W-1:0] tick_total;
    t_time_stamp       expected_stamps[$];
    int                fail_count = 0;

    function automatic t_time_stamp stamp_from_ticks(input logic [TICK_W-1:0] ticks,
                                                     input logic [WORD_W-1:0] divisor);
        logic [TICK_W-1:0] scaled;
        logic [TICK_W-1:0] quotient;
        t_time_stamp       stamp;
        scaled = ticks * 64'd1000;
        // a zero divisor yields an all-ones quotient
        quotient = (divisor == '0) ? '1 : scaled / {32'd0, divisor};
        stamp.tick_total_low = ticks[WORD_W-1:0];
        stamp.millis         = quotient[WORD_W-1:0];
        stamp.minutes        = MIN_W'(stamp.millis / 32'd60000);
        stamp.seconds        = SEC_W'((stamp.millis / 32'd1000) % 32'd60);
        stamp.deciseconds    = DECI_W'((stamp.millis / 32'd100) % 32'd10);
        return stamp;
    endfunction

    task automatic fold_reading(input logic [WORD_W-1:0] sample);
        logic [WORD_W-1:0] elapsed;
        // a larger sample means the counter wrapped through the reload value
        if (sample > last_reading) begin
            elapsed = last_reading + (reload_value - sample);
        end else begin
            elapsed = last_reading - sample;
        end
        tick_total   = tick_total + {32'd0, elapsed};
        last_reading = sample;
        expected_stamps.push_back(stamp_from_ticks(tick_total, tick_divisor));
    endtask

    task automatic compare_stamp(input t_time_stamp got);
        t_time_stamp want;
        if (expected_stamps.size() == 0) begin
            $error("time stamp with no reading outstanding: %h", got);
            fail_count++;
        end else begin
            want = expected_stamps.pop_front();
            if (got.tick_total_low !== want.tick_total_low) begin
                $error("tick_total_low: expected %0d, got %0d",
                       want.tick_total_low, got.tick_total_low);
                fail_count++;
            end
            if (got.millis !== want.millis) begin
                $error("millis: expected %0d, got %0d", want.millis, got.millis);
                fail_count++;
            end
            if (got.minutes !== want.minutes) begin
                $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
                fail_count++;
            end
            if (got.seconds !== want.seconds) begin
                $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
                fail_count++;
            end
            if (got.deciseconds !== want.deciseconds) begin
                $error("deciseconds: expected %0d, got %0d",
                       want.deciseconds, got.deciseconds);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reload_value = RELOAD_RST;
            tick_divisor = DIVISOR_RST;
            tick_total   = '0;
            last_reading = RELOAD_RST;
            expected_stamps.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_stamp(i_m_tdata[90:0]);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_DIVISOR) begin
                    tick_divisor = i_pwdata;
                end else begin
                    // a new reload restarts the count
                    reload_value = i_pwdata;
                    tick_total   = '0;
                    last_reading = i_pwdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fold_reading(i_s_tdata);
            end
        end
        o_pending    <= expected_stamps.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/down_counter_time_accumulator_top_tb.sv =====
// Testbench top for the down-counter time accumulator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module down_counter_time_accumulator_top_tb
    import dcta_pkg::*;
();

    localparam int PHASES          = 8;
    localparam int READINGS_PER_PHASE = 210;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 80;
    localparam logic [2:0] ADDR_RELOAD  = {REG_RELOAD, 2'b00};
    localparam logic [2:0] ADDR_DIVISOR = {REG_DIVISOR, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // [31:0] counter_reading
    logic        m_tvalid;
    logic        m_tready;
    // [31:0] tick_total_low, [63:32] millis, [80:64] minutes,
    // [86:81] seconds, [90:87] deciseconds, [95:91] zero
    logic [95:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          fail_count;
    int          readings_sent = 0;
    int          stamps_taken  = 0;
    int          reg_writes    = 0;
    int          idle_cycles   = 0;
    int          sender_idle_pct = 0;
    bit          quiet = 1'b0;
    logic [31:0] last_reading;
    logic [31:0] cur_reload;
    logic [31:0] new_reload;
    logic [31:0] new_divisor;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    down_counter_time_accumulator_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    elapsed_time_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (m_tvalid && m_tready) begin
            stamps_taken <= stamps_taken + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL down_counter_time_accumulator_top");
            $finish;
        end
    end

    // Receiver: ready stretches broken by random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
        if (addr == ADDR_RELOAD) begin
            cur_reload   = value;
            last_reading = value;
        end
    endtask

    task automatic send_reading(input logic [31:0] value);
        if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        readings_sent++;
        last_reading = value;
    endtask

    // Hold off until every outstanding time stamp has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly a counter counting down with random steps, wrapping through reload
    function automatic logic [31:0] next_reading();
        logic [31:0] step;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            step = $urandom >> $urandom_range(0, 31);
            if (step <= last_reading) return last_reading - step;
            return cur_reload - (step - last_reading);
        end
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return cur_reload;
            2: return cur_reload + 32'd1;
            3: return '1;
            4: return last_reading;
            default: return last_reading + 32'd1;
        endcase
    endfunction

    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_reload   = RELOAD_RST;
        last_reading = RELOAD_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no change, plain step, sample above reload, edges
        send_reading(32'd65535);
        send_reading(32'd0);
        send_reading(32'hFFFF_FFFF);
        send_reading(32'd1);
        send_reading(32'h8000_0000);

        // Zero divisor saturates millis
        drain();
        write_register(ADDR_DIVISOR, 32'd0);
        send_reading(32'h7FFF_FFFF);
        send_reading(32'd0);

        // Divisor of one overflows millis past 32 bits
        drain();
        write_register(ADDR_DIVISOR, 32'd1);
        send_reading(32'hFFFF_FFFF);
        send_reading(32'd0);

        drain();
        write_register(ADDR_DIVISOR, 32'hFFFF_FFFF);
        send_reading(32'h0000_1000);

        // Zero reload: every rise wraps modulo 2^32
        drain();
        write_register(ADDR_RELOAD, 32'd0);
        send_reading(32'd5);
        send_reading(32'd0);

        drain();
        write_register(ADDR_RELOAD, 32'hFFFF_FFFF);
        write_register(ADDR_DIVISOR, 32'd1000);
        send_reading(32'd0);
        send_reading(32'hFFFF_FFFF);
        send_reading(32'h1234_5678);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            quiet = (phase == PHASES - 1);
            sender_idle_pct = (quiet || phase % 3 == 1) ? 0 : $urandom_range(10, 50);
            case ($urandom_range(0, 5))
                0: new_reload = '0;
                1: new_reload = '1;
                2: new_reload = RELOAD_RST;
                3: new_reload = $urandom_range(1, 1000);
                default: new_reload = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0: new_divisor = 32'd1;
                1: new_divisor = '1;
                2: new_divisor = 32'd1000;
                3: new_divisor = DIVISOR_RST;
                4: new_divisor = '0;
                5: new_divisor = $urandom_range(1, 100);
                default: new_divisor = $urandom;
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_register(ADDR_RELOAD, new_reload);
                write_register(ADDR_DIVISOR, new_divisor);
            end else begin
                write_register(ADDR_DIVISOR, new_divisor);
                write_register(ADDR_RELOAD, new_reload);
            end
            for (int n = 0; n < READINGS_PER_PHASE; n++) begin
                if (phase == 2 && n == READINGS_PER_PHASE / 2) begin
                    drain();
                end
                send_reading(next_reading());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d counter readings, %0d time stamps checked, %0d register writes",
                 readings_sent, stamps_taken, reg_writes);
        $display("including zero divisor, wrapped samples and zero and full-range reload values");
        if (fail_count == 0) begin
            $display("PASS down_counter_time_accumulator_top");
        end else begin
            $display("FAIL down_counter_time_accumulator_top");
        end
        $finish;
    end

endmodule

// ===== down_counter_time_accumulator_top.f =====
rtl/dcta_pkg.sv
rtl/dcta_ctrl.sv
rtl/dcta_dp.sv
rtl/down_counter_time_accumulator_top.sv
tb/sv/elapsed_time_checker.sv
tb/sv/down_counter_time_accumulator_top_tb.sv
